/* design/msp_frame_receiver_macros.svh */
// Assertion macros for the MSP frame receiver checker.
// Included by msp_frame_receiver_chk.sv; needs clk_i and rst_ni in scope.
`ifndef MSP_FRAME_RECEIVER_MACROS_SVH
`define MSP_FRAME_RECEIVER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MSPFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MSPFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/mspfr_pkg.sv */
// Shared types and constants of the MSP frame receiver.
// No dependencies; imported by every other file of the block but the macros header.
`timescale 1ns / 1ps

package mspfr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int IDX_W  = 5;

  localparam int DEFAULT_PAYLOAD_DEPTH = 32;

  localparam logic [BYTE_W-1:0] ASCII_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] ASCII_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] ASCII_LT     = 8'h3C;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_DOLLAR  = 3'd1,
    ST_M       = 3'd2,
    ST_ARROW   = 3'd3,
    ST_SIZE    = 3'd4,
    ST_PAYLOAD = 3'd5
  } parse_state_e;

  // Payload store write from the parser.
  typedef struct packed {
    logic              en;
    logic [LEN_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // Frame release from the parser to the readout.
  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] cmd;
    logic [LEN_W-1:0]  len;
  } frame_start_t;

endpackage

/* design/mspfr_if.sv */
// Valid/ready channel interfaces of the MSP frame receiver.
// Depends on mspfr_pkg for field widths.
`timescale 1ns / 1ps

interface mspfr_rx_if
  import mspfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mspfr_res_if
  import mspfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] command_code;
  logic [LEN_W-1:0]  payload_length;
  logic              has_payload;
  logic [IDX_W-1:0]  byte_index;
  logic [BYTE_W-1:0] payload_byte;
  logic              last;

  modport source (output valid, output command_code, output payload_length,
                  output has_payload, output byte_index, output payload_byte,
                  output last, input ready);
  modport sink   (input valid, input command_code, input payload_length,
                  input has_payload, input byte_index, input payload_byte,
                  input last, output ready);
endinterface

/* design/msp_frame_receiver.sv */
// Top level of the MSP frame receiver: header/size/checksum parser.
// Depends on mspfr_pkg, mspfr_if and mspfr_frame_buf.
`timescale 1ns / 1ps

// MSP v1 request frame receiver. Feed received serial bytes, one per rx_i
// word, and take one res_o word per payload byte of every frame that
// passes its checksum ('$' 'M' '<' size command payload checksum, checksum
// the XOR of size, command and payload). A bad header byte, a size above
// PAYLOAD_DEPTH or a bad checksum drops the frame with no output and the
// parser goes back to hunting for '$'. An empty frame gives one word with
// has_payload low. Each word carries the command and length, byte_index
// and last marks the final word of the frame. Rate: while a frame is being
// parsed, one byte is taken every cycle. After a good checksum byte, rx_i
// ready stays low while the payload is read back out of the store, one
// entry per cycle through its single read port while res_o does not stall.
// The output register lets the last word of a frame wait on res_o while the
// next frame's bytes come in. The store needs no clearing pass after reset:
// only entries written in the current frame are read.
module msp_frame_receiver
  import mspfr_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mspfr_rx_if.sink    rx_i,
  mspfr_res_if.source res_o
);

  localparam logic [BYTE_W-1:0] DepthByte = BYTE_W'(PAYLOAD_DEPTH);
  localparam logic [LEN_W-1:0]  DepthLen  = LEN_W'(PAYLOAD_DEPTH);

  parse_state_e      state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] csum_q, csum_d;
  logic [BYTE_W-1:0] cmd_q, cmd_d;

  logic              busy;
  logic              acc;
  logic [BYTE_W-1:0] c;
  store_wr_t         wr;
  frame_start_t      start;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Frame bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      cnt_q  <= '0;
      csum_q <= '0;
      cmd_q  <= '0;
    end else begin
      len_q  <= len_d;
      cnt_q  <= cnt_d;
      csum_q <= csum_d;
      cmd_q  <= cmd_d;
    end
  end

  always_comb begin
    c       = rx_i.rx_byte;
    acc     = rx_i.valid && !busy;
    state_d = state_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    csum_d  = csum_q;
    cmd_d   = cmd_q;

    wr.en      = 1'b0;
    wr.addr    = cnt_q;
    wr.data    = c;
    start.en   = 1'b0;
    start.cmd  = cmd_q;
    start.len  = len_q;

    if (acc) begin
      case (state_q)
        ST_DOLLAR: begin
          state_d = (c == ASCII_M) ? ST_M : ST_IDLE;
        end
        ST_M: begin
          state_d = (c == ASCII_LT) ? ST_ARROW : ST_IDLE;
        end
        ST_ARROW: begin
          // Drop an oversized frame; the size byte is not a new '$'.
          if (c > DepthByte) begin
            state_d = ST_IDLE;
          end else begin
            len_d   = c[LEN_W-1:0];
            csum_d  = c;
            cnt_d   = '0;
            state_d = ST_SIZE;
          end
        end
        ST_SIZE: begin
          csum_d  = csum_q ^ c;
          cmd_d   = c;
          state_d = ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          if (cnt_q < len_q && cnt_q < DepthLen) begin
            // Store the payload byte and fold it into the checksum.
            wr.en  = 1'b1;
            csum_d = csum_q ^ c;
            cnt_d  = cnt_q + LEN_W'(1);
          end else begin
            // Checksum byte: release the frame on a match, drop it otherwise.
            start.en = (csum_q == c);
            state_d  = ST_IDLE;
          end
        end
        default: begin
          state_d = (c == ASCII_DOLLAR) ? ST_DOLLAR : ST_IDLE;
        end
      endcase
    end
  end

  // Hold input while a released frame is being read out of the store.
  assign rx_i.ready = !busy;

  mspfr_frame_buf #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_frame_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .start_i (start),
    .busy_o  (busy),
    .res_o   (res_o)
  );

endmodule

/* design/mspfr_frame_buf.sv */
// Payload store and frame readout of the MSP frame receiver.
// Depends on mspfr_pkg and mspfr_if.
`timescale 1ns / 1ps

module mspfr_frame_buf
  import mspfr_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  store_wr_t         wr_i,
  input  frame_start_t      start_i,
  output logic              busy_o,
  mspfr_res_if.source       res_o
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic [BYTE_W-1:0] mem [PAYLOAD_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  logic              act_q, act_d;
  logic [LEN_W-1:0]  iss_q, iss_d;
  logic [BYTE_W-1:0] cmd_q, cmd_d;
  logic [LEN_W-1:0]  len_q, len_d;

  logic              s1_valid_q, s1_valid_d;
  logic [IDX_W-1:0]  s1_idx_q, s1_idx_d;
  logic              s1_has_q, s1_has_d;
  logic              s1_last_q, s1_last_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_cmd_q, out_cmd_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic              out_has_q, out_has_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  logic [LEN_W-1:0]  total;
  logic              s1_move;
  logic              issue;
  logic              rd_en;

  always_comb begin
    total   = (len_q == '0) ? LEN_W'(1) : len_q;
    s1_move = s1_valid_q && (!out_valid_q || res_o.ready);
    issue   = act_q && (!s1_valid_q || s1_move);
    rd_en   = issue && (len_q != '0);

    act_d       = act_q;
    iss_d       = iss_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    s1_valid_d  = s1_valid_q;
    s1_idx_d    = s1_idx_q;
    s1_has_d    = s1_has_q;
    s1_last_d   = s1_last_q;
    out_valid_d = out_valid_q;
    out_cmd_d   = out_cmd_q;
    out_len_d   = out_len_q;
    out_has_d   = out_has_q;
    out_idx_d   = out_idx_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (start_i.en) begin
      act_d = 1'b1;
      iss_d = '0;
      cmd_d = start_i.cmd;
      len_d = start_i.len;
    end

    // Drain the read stage into the output register.
    if (s1_move) begin
      out_valid_d = 1'b1;
      out_cmd_d   = cmd_q;
      out_len_d   = len_q;
      out_has_d   = s1_has_q;
      out_idx_d   = s1_idx_q;
      out_byte_d  = s1_has_q ? rdata_q : '0;
      out_last_d  = s1_last_q;
      s1_valid_d  = 1'b0;
    end else if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    // Issue the next store read; an empty frame issues one dataless word.
    if (issue) begin
      s1_valid_d = 1'b1;
      s1_idx_d   = iss_q[IDX_W-1:0];
      s1_has_d   = (len_q != '0);
      s1_last_d  = (iss_q + LEN_W'(1) == total);
      iss_d      = iss_q + LEN_W'(1);
      if (iss_q + LEN_W'(1) == total) begin
        act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem[iss_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      iss_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      act_q       <= act_d;
      iss_q       <= iss_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    len_q      <= len_d;
    s1_idx_q   <= s1_idx_d;
    s1_has_q   <= s1_has_d;
    s1_last_q  <= s1_last_d;
    out_cmd_q  <= out_cmd_d;
    out_len_q  <= out_len_d;
    out_has_q  <= out_has_d;
    out_idx_q  <= out_idx_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign busy_o               = act_q || s1_valid_q;
  assign res_o.valid          = out_valid_q;
  assign res_o.command_code   = out_cmd_q;
  assign res_o.payload_length = out_len_q;
  assign res_o.has_payload    = out_has_q;
  assign res_o.byte_index     = out_idx_q;
  assign res_o.payload_byte   = out_byte_q;
  assign res_o.last           = out_last_q;

endmodule

/* design/msp_frame_receiver_chk.sv */
// Port-level assertion checker for the MSP frame receiver, with its bind.
// Depends on msp_frame_receiver_macros.svh and msp_frame_receiver.
`timescale 1ns / 1ps
`include "msp_frame_receiver_macros.svh"

module msp_frame_receiver_chk
  import mspfr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] command_code_i,
  input logic [LEN_W-1:0]  payload_length_i,
  input logic              has_payload_i,
  input logic [IDX_W-1:0]  byte_index_i,
  input logic [BYTE_W-1:0] payload_byte_i,
  input logic              last_i
);

  `MSPFR_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(command_code_i) && $stable(byte_index_i) && $stable(payload_byte_i) && $stable(last_i), "result word changed while stalled")

  `MSPFR_ASSERT(a_empty_word, out_valid_i && !has_payload_i |-> last_i && byte_index_i == '0 && payload_byte_i == '0 && payload_length_i == '0, "malformed empty-frame word")

  `MSPFR_ASSERT(a_last_pos, out_valid_i && has_payload_i |-> ({1'b0, byte_index_i} < payload_length_i) && (last_i == ({1'b0, byte_index_i} + 6'd1 == payload_length_i)), "byte index or last flag out of place")

  `MSPFR_ASSERT(a_ready_drop, $fell(in_ready_i) |-> $past(in_valid_i && in_ready_i), "input stalled without a preceding byte")

  `MSPFR_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_i, "result valid during reset")

endmodule

bind msp_frame_receiver msp_frame_receiver_chk u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (rx_i.valid),
  .in_ready_i       (rx_i.ready),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .command_code_i   (res_o.command_code),
  .payload_length_i (res_o.payload_length),
  .has_payload_i    (res_o.has_payload),
  .byte_index_i     (res_o.byte_index),
  .payload_byte_i   (res_o.payload_byte),
  .last_i           (res_o.last)
);

/* tb/tb_msp_frame_receiver.sv */
// Self-checking testbench for msp_frame_receiver: byte stream in, frame words out.
// Depends on mspfr_pkg, mspfr_if and the receiver RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_msp_frame_receiver;
  import mspfr_pkg::*;

  localparam int PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH;
  // Cycles with no word moving on either side before the run is declared hung.
  // The longest legal quiet stretch is the output hold-off below.
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLDOFF_LEN   = 300;
  localparam int DRAIN_CYCLES  = 40;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  // One output word as the receiver should present it.
  typedef struct packed {
    logic [BYTE_W-1:0] cmd;
    logic [LEN_W-1:0]  len;
    logic              has_data;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic              last_flag;
  } frame_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mspfr_rx_if  rx_if ();
  mspfr_res_if res_if ();

  msp_frame_receiver #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: tracks the receiver's state byte by byte and queues the
  // words each accepted byte releases.
  // ---------------------------------------------------------------------------
  parse_state_e      frame_state = ST_IDLE;
  logic [LEN_W-1:0]  frame_len   = '0;
  logic [LEN_W-1:0]  frame_count = '0;
  logic [BYTE_W-1:0] frame_csum  = '0;
  logic [BYTE_W-1:0] frame_cmd   = '0;
  logic [BYTE_W-1:0] frame_store [PAYLOAD_DEPTH];

  frame_word_t expected_words[$];

  int  err_count    = 0;
  int  items_sent   = 0;
  int  quiet_cycles = 0;
  int  holdoff_left = 0;
  bit  src_gaps     = 1'b1;
  bit  sink_gaps    = 1'b1;

  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    frame_word_t w;
    int          i;
    case (frame_state)
      ST_DOLLAR: begin
        frame_state = (b == ASCII_M) ? ST_M : ST_IDLE;
      end
      ST_M: begin
        frame_state = (b == ASCII_LT) ? ST_ARROW : ST_IDLE;
      end
      ST_ARROW: begin
        // Oversized length: drop back to hunting, and do not treat it as a start.
        if (int'(b) > PAYLOAD_DEPTH) begin
          frame_state = ST_IDLE;
        end else begin
          frame_len   = b[LEN_W-1:0];
          frame_csum  = b;
          frame_count = '0;
          frame_state = ST_SIZE;
        end
      end
      ST_SIZE: begin
        frame_csum  = frame_csum ^ b;
        frame_cmd   = b;
        frame_state = ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        if (frame_count < frame_len && int'(frame_count) < PAYLOAD_DEPTH) begin
          frame_csum                            = frame_csum ^ b;
          frame_store[frame_count[IDX_W-1:0]]   = b;
          frame_count                           = frame_count + LEN_W'(1);
        end else begin
          // Checksum byte: release the frame only on a match.
          if (frame_csum == b) begin
            w.cmd = frame_cmd;
            w.len = frame_len;
            if (frame_len == '0) begin
              w.has_data  = 1'b0;
              w.idx       = '0;
              w.data      = '0;
              w.last_flag = 1'b1;
              expected_words.push_back(w);
            end else begin
              for (i = 0; i < int'(frame_len) && i < PAYLOAD_DEPTH; i++) begin
                w.has_data  = 1'b1;
                w.idx       = IDX_W'(i);
                w.data      = frame_store[i];
                w.last_flag = (i + 1 == int'(frame_len));
                expected_words.push_back(w);
              end
            end
          end
          frame_state = ST_IDLE;
        end
      end
      default: begin
        frame_state = (b == ASCII_DOLLAR) ? ST_DOLLAR : ST_IDLE;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Mismatch reporting and output checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Sample at the falling edge: inputs only move at the rising edge, so what
  // is seen here is exactly what the next rising edge will accept.
  always @(negedge clk_i) begin : res_check
    frame_word_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word with nothing pending: cmd 0x%0h idx %0d",
                                  res_if.command_code, res_if.byte_index));
      end else begin
        want = expected_words.pop_front();
        check_field("command_code",   int'(res_if.command_code),   int'(want.cmd));
        check_field("payload_length", int'(res_if.payload_length), int'(want.len));
        check_field("has_payload",    int'(res_if.has_payload),    int'(want.has_data));
        check_field("byte_index",     int'(res_if.byte_index),     int'(want.idx));
        check_field("payload_byte",   int'(res_if.payload_byte),   int'(want.data));
        check_field("last",           int'(res_if.last),           int'(want.last_flag));
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either channel.
  always @(negedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no progress, %0d words still pending",
                 $realtime, expected_words.size());
        $display("msp_frame_receiver test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, plus a long hold-off on request that it
  // counts down itself.
  // ---------------------------------------------------------------------------
  initial begin : res_sink
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_left > 0) begin
        res_if.ready <= 1'b0;
        holdoff_left--;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------
  // Offer one byte and return at the rising edge that takes it. Called at a
  // rising edge; drives valid exactly once per time step.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    bit took;
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do begin
      @(negedge clk_i);
      took = rx_if.ready;
      @(posedge clk_i);
    end while (!took);
    items_sent++;
    parse_rx_byte(b);
  endtask

  // Send a complete request frame; a nonzero csum_xor corrupts the checksum.
  task automatic send_frame(input logic [BYTE_W-1:0] cmd, input byte_q_t body,
                            input logic [BYTE_W-1:0] csum_xor);
    logic [BYTE_W-1:0] csum;
    csum = BYTE_W'(body.size()) ^ cmd;
    send_byte(ASCII_DOLLAR);
    send_byte(ASCII_M);
    send_byte(ASCII_LT);
    send_byte(BYTE_W'(body.size()));
    send_byte(cmd);
    foreach (body[i]) begin
      send_byte(body[i]);
      csum = csum ^ body[i];
    end
    send_byte(csum ^ csum_xor);
  endtask

  function automatic byte_q_t random_body(input int len);
    byte_q_t body;
    for (int i = 0; i < len; i++) body.push_back(BYTE_W'($urandom_range(0, 255)));
    return body;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty frame: one word, no data, last set.
  task automatic test_empty_frame();
    byte_q_t body;
    send_frame(8'hFF, body, 8'h00);
  endtask

  // Wrong byte after '$', then wrong byte after 'M'; neither restarts a frame.
  task automatic test_bad_header();
    send_byte(ASCII_DOLLAR);
    send_byte(8'h00);
    send_byte(ASCII_DOLLAR);
    send_byte(ASCII_M);
    send_byte(ASCII_M);
  endtask

  // Size byte '$' is above the depth: drop, and it must not count as a start.
  task automatic test_oversized_size();
    send_byte(ASCII_DOLLAR);
    send_byte(ASCII_M);
    send_byte(ASCII_LT);
    send_byte(ASCII_DOLLAR);
  endtask

  // Bad checksum: the frame vanishes without a word.
  task automatic test_bad_checksum();
    byte_q_t body;
    body.push_back(8'h81);
    send_frame(8'h5A, body, 8'h01);
  endtask

  // Mostly well-formed frames with random content, mixed with broken frames
  // and line noise. Idling on both sides switches on and off per frame.
  task automatic test_random_frames();
    int      kind;
    int      len;
    byte_q_t body;
    // Full-depth frame first so the largest length and index always appear.
    send_frame(BYTE_W'($urandom_range(0, 255)), random_body(PAYLOAD_DEPTH), 8'h00);
    while (items_sent < 170) begin
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len  = (kind < 5) ? PAYLOAD_DEPTH : $urandom_range(0, 7);
        body = random_body(len);
        send_frame(BYTE_W'($urandom_range(0, 255)), body, 8'h00);
      end else if (kind < 78) begin
        body = random_body($urandom_range(0, 6));
        send_frame(BYTE_W'($urandom_range(0, 255)), body, BYTE_W'($urandom_range(1, 255)));
      end else if (kind < 84) begin
        send_byte(ASCII_DOLLAR);
        send_byte(ASCII_M);
        send_byte(ASCII_LT);
        send_byte(BYTE_W'($urandom_range(PAYLOAD_DEPTH + 1, 255)));
      end else if (kind < 90) begin
        send_byte(ASCII_DOLLAR);
        if ($urandom_range(0, 1)) send_byte(ASCII_M);
        send_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Hold the output off for a long stretch while frames keep coming, so the
  // output register fills and the receiver has to stall its input.
  task automatic test_output_holdoff();
    holdoff_left = HOLDOFF_LEN;
    repeat (4) send_frame(BYTE_W'($urandom_range(0, 255)), random_body(8), 8'h00);
  endtask

  // Closing stretch: no idling on either side, frames back to back.
  task automatic test_back_to_back();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    repeat (5) send_frame(BYTE_W'($urandom_range(0, 255)),
                          random_body($urandom_range(0, 7)), 8'h00);
  endtask

  initial begin : main_seq
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_frame();
    test_bad_header();
    test_oversized_size();
    test_bad_checksum();
    test_random_frames();
    test_output_holdoff();
    test_back_to_back();
    rx_if.valid <= 1'b0;

    // Let the readout drain, then give stray words a chance to show up.
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("msp_frame_receiver test passed");
    end else begin
      $display("msp_frame_receiver test failed");
    end
    $finish;
  end

endmodule
